// File: hw/rtl/cdbr_pkg.sv
`timescale 1ns / 1ps

package cdbr_pkg;

   localparam int DIV_SLOTS   = 4;
   localparam int NUM_BUSES   = 2;
   localparam int NUM_OUTS    = 3;
   localparam int NUM_SOURCES = 2 + DIV_SLOTS;
   localparam int ROUTE_BITS  = 18;
   localparam int OUT_ROUTE_BASE = 12;

   localparam int LIMIT_BITS = 4;
   localparam int SCALE_BITS = 11;
   localparam int GATE_BITS  = 20;
   localparam int SEL_BITS   = 6;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [GATE_BITS-1:0] GATE_MAX = '1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROUTE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_A  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_B  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_C  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_D  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GATE     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_GATE = 3'd6;

   localparam logic [GATE_BITS-1:0]  GATE_RESET     = 20'd24000;
   localparam logic [GATE_BITS-1:0]  MIN_GATE_RESET = 20'd48;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = 4'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEL,
      ST_START,
      ST_WAIT,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic                done;
      logic [SEL_BITS-1:0] rem;
   } mod_rsp_type;

endpackage

// File: hw/rtl/cdbr_mod_unit.sv
`timescale 1ns / 1ps

module cdbr_mod_unit #(
   parameter int COUNT_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [COUNT_BITS-1:0]          dividend,
   input  logic [cdbr_pkg::SEL_BITS-1:0]  divisor,
   output cdbr_pkg::mod_rsp_type          rsp
);
   import cdbr_pkg::*;

   localparam int CNT_W = $clog2(COUNT_BITS + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] num_ff, num_in;
   logic [SEL_BITS-1:0]   rem_ff, rem_in;
   logic [SEL_BITS-1:0]   div_ff, div_in;
   logic                  done_ff, done_in;
   logic [SEL_BITS:0]     trial;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      trial   = {rem_ff, num_ff[COUNT_BITS-1]};
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(COUNT_BITS);
         num_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[COUNT_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SEL_BITS'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[SEL_BITS-1:0];
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

// File: hw/rtl/cdbr_gate_calc.sv
`timescale 1ns / 1ps

module cdbr_gate_calc (
   input  logic                                  clock,
   input  logic [cdbr_pkg::GATE_BITS-1:0]        gate_ticks,
   input  logic [cdbr_pkg::GATE_BITS-1:0]        min_gate_ticks,
   input  logic signed [cdbr_pkg::SCALE_BITS-1:0] gate_scale,
   output logic [cdbr_pkg::GATE_BITS-1:0]        gate_len
);
   import cdbr_pkg::*;

   localparam int PROD_BITS = GATE_BITS + 1 + SCALE_BITS;

   logic signed [GATE_BITS:0]     ticks_s;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [PROD_BITS-10:0]         scaled;
   logic [GATE_BITS-1:0]          gate_ff, gate_in;

   assign ticks_s = $signed({1'b0, gate_ticks});
   assign prod_in = PROD_BITS'(ticks_s * gate_scale);

   always_comb begin
      scaled = prod_ff[PROD_BITS-1] ? '0 : prod_ff[PROD_BITS-2:8];
      if (scaled > (PROD_BITS-9)'(GATE_MAX)) begin
         gate_in = GATE_MAX;
      end else if (scaled < (PROD_BITS-9)'(min_gate_ticks)) begin
         gate_in = min_gate_ticks;
      end else begin
         gate_in = scaled[GATE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      gate_ff <= gate_in;
   end

   assign gate_len = gate_ff;

endmodule

// File: hw/rtl/clock_divider_bus_router_top.sv
`timescale 1ns / 1ps

// Clock divider with a two-bus trigger routing matrix. One item per sample tick
// carries the detected clock, reset and aux edges plus Q8 scales; one result item
// (three mixed outputs and an overlap warning) comes back per item. The block takes
// one item at a time: an item occupies it until each divider built (at most four)
// has been run in turn through the single shared remainder unit, which retires
// one counter bit per cycle. A finished result waits in the output register while
// the next item is taken.
module clock_divider_bus_router_top #(
   parameter int COUNT_BITS   = 32,
   parameter int NUM_DIVIDERS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // clock_edge, reset_edge, aux_edge_a, aux_edge_b, div_scale_a..d, gate_scale
   input  logic [63:0]                          req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // mix_out_a, mix_out_b, mix_out_c, overlap_warning
   output logic [7:0]                           rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [cdbr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cdbr_pkg::GATE_BITS-1:0]       csr_wdata
);
   import cdbr_pkg::*;

   localparam int ACTIVE_DIVS = (NUM_DIVIDERS < DIV_SLOTS) ? NUM_DIVIDERS : DIV_SLOTS;
   localparam int IDX_W = $clog2(DIV_SLOTS);

   // configuration
   logic [ROUTE_BITS-1:0] route_ff, route_in;
   logic [LIMIT_BITS-1:0] limit_ff [DIV_SLOTS];
   logic [LIMIT_BITS-1:0] limit_in [DIV_SLOTS];
   logic [GATE_BITS-1:0]  gate_ticks_ff, gate_ticks_in;
   logic [GATE_BITS-1:0]  min_gate_ff, min_gate_in;

   // state
   seq_state_type         state_ff, state_in;
   logic [COUNT_BITS-1:0] step_ff, step_in;
   logic [GATE_BITS-1:0]  pulse_ff [NUM_BUSES];
   logic [GATE_BITS-1:0]  pulse_in [NUM_BUSES];
   logic [NUM_BUSES-1:0]  bus_live_ff, bus_live_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DIV_SLOTS-1:0]  fire_ff, fire_in;
   logic [SEL_BITS-1:0]   sel_ff, sel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [3:0]            rsp_data_ff, rsp_data_in;

   // latched item
   logic                         clk_edge_ff, clk_edge_in;
   logic [1:0]                   aux_ff, aux_in;
   logic signed [SCALE_BITS-1:0] scale_ff [DIV_SLOTS];
   logic signed [SCALE_BITS-1:0] scale_in [DIV_SLOTS];
   logic signed [SCALE_BITS-1:0] gscale_ff, gscale_in;

   logic                  accept;
   logic                  mod_start;
   logic                  out_load;
   logic                  last_div;
   mod_rsp_type           mod_rsp;
   logic [GATE_BITS-1:0]  gate_len;

   logic signed [SCALE_BITS-1:0] cur_scale;
   logic [SCALE_BITS-1:0]        mag;
   logic [LIMIT_BITS+SCALE_BITS-1:0] sel_prod;
   logic [NUM_SOURCES-1:0]       src_fire;
   logic [NUM_BUSES-1:0]         bus_trig;
   logic [NUM_OUTS-1:0]          mix;
   logic                         warn;

   cdbr_mod_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (step_ff),
      .divisor  (sel_ff + 1'b1),
      .rsp      (mod_rsp)
   );

   cdbr_gate_calc u_gate (
      .clock          (clock),
      .gate_ticks     (gate_ticks_ff),
      .min_gate_ticks (min_gate_ff),
      .gate_scale     (gscale_ff),
      .gate_len       (gate_len)
   );

   assign last_div = (idx_ff == IDX_W'(ACTIVE_DIVS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SEL;
         ST_SEL:    state_in = ST_START;
         ST_START:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (mod_rsp.done) begin
               state_in = last_div ? ST_FINISH : ST_SEL;
            end
         end
         ST_FINISH: if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mod_start  = (state_ff == ST_START);
      out_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   assign accept = req_tvalid && req_tready;

   // configuration writes
   always_comb begin
      route_in      = route_ff;
      limit_in      = limit_ff;
      gate_ticks_in = gate_ticks_ff;
      min_gate_in   = min_gate_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROUTE:    route_in      = csr_wdata[ROUTE_BITS-1:0];
            CSR_LIMIT_A:  limit_in[0]   = csr_wdata[LIMIT_BITS-1:0];
            CSR_LIMIT_B:  limit_in[1]   = csr_wdata[LIMIT_BITS-1:0];
            CSR_LIMIT_C:  limit_in[2]   = csr_wdata[LIMIT_BITS-1:0];
            CSR_LIMIT_D:  limit_in[3]   = csr_wdata[LIMIT_BITS-1:0];
            CSR_GATE:     gate_ticks_in = csr_wdata;
            CSR_MIN_GATE: min_gate_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // datapath
   always_comb begin
      step_in      = step_ff;
      pulse_in     = pulse_ff;
      bus_live_in  = bus_live_ff;
      idx_in       = idx_ff;
      fire_in      = fire_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      clk_edge_in  = clk_edge_ff;
      aux_in       = aux_ff;
      scale_in     = scale_ff;
      gscale_in    = gscale_ff;

      cur_scale = scale_ff[idx_ff];
      mag       = cur_scale[SCALE_BITS-1] ? SCALE_BITS'(-cur_scale) : cur_scale;
      sel_prod  = {{SCALE_BITS{1'b0}}, limit_ff[idx_ff]} * {{LIMIT_BITS{1'b0}}, mag};

      src_fire = {fire_ff, aux_ff};
      bus_trig = '0;
      mix      = '0;
      warn     = 1'b0;
      for (int b = 0; b < NUM_BUSES; b++) begin
         for (int s = 0; s < NUM_SOURCES; s++) begin
            if (src_fire[s] && route_ff[2*s+b]) bus_trig[b] = 1'b1;
         end
      end
      for (int o = 0; o < NUM_OUTS; o++) begin
         for (int b = 0; b < NUM_BUSES; b++) begin
            if (route_ff[OUT_ROUTE_BASE+2*o+b]) begin
               if (bus_live_ff[b]) mix[o] = 1'b1;
               if (bus_live_ff[b] && bus_trig[b]) warn = 1'b1;
            end
         end
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (accept) begin
         clk_edge_in = req_tdata[0];
         aux_in      = req_tdata[3:2];
         for (int k = 0; k < DIV_SLOTS; k++) begin
            scale_in[k] = req_tdata[4+SCALE_BITS*k +: SCALE_BITS];
         end
         gscale_in = req_tdata[4+SCALE_BITS*DIV_SLOTS +: SCALE_BITS];
         if (req_tdata[1]) begin
            step_in = '0;
         end else if (req_tdata[0]) begin
            step_in = step_ff + 1'b1;
         end
         for (int b = 0; b < NUM_BUSES; b++) begin
            bus_live_in[b] = (pulse_ff[b] != '0);
            if (pulse_ff[b] != '0) pulse_in[b] = pulse_ff[b] - 1'b1;
         end
         idx_in  = '0;
         fire_in = '0;
      end

      if (state_ff == ST_SEL) begin
         sel_in = sel_prod[SEL_BITS+7:8];
      end

      if (state_ff == ST_WAIT && mod_rsp.done) begin
         fire_in[idx_ff] = clk_edge_ff && (mod_rsp.rem == sel_ff);
         if (!last_div) idx_in = idx_ff + 1'b1;
      end

      if (out_load) begin
         for (int b = 0; b < NUM_BUSES; b++) begin
            if (bus_trig[b]) pulse_in[b] = gate_len;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {warn, mix};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_ff      <= '0;
         limit_ff      <= '{default: LIMIT_RESET};
         gate_ticks_ff <= GATE_RESET;
         min_gate_ff   <= MIN_GATE_RESET;
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         pulse_ff      <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         route_ff      <= route_in;
         limit_ff      <= limit_in;
         gate_ticks_ff <= gate_ticks_in;
         min_gate_ff   <= min_gate_in;
         state_ff      <= state_in;
         step_ff       <= step_in;
         pulse_ff      <= pulse_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bus_live_ff <= bus_live_in;
      idx_ff      <= idx_in;
      fire_ff     <= fire_in;
      sel_ff      <= sel_in;
      rsp_data_ff <= rsp_data_in;
      clk_edge_ff <= clk_edge_in;
      aux_ff      <= aux_in;
      scale_ff    <= scale_in;
      gscale_ff   <= gscale_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule
